// ===== rtl/ostb_pkg.sv =====
// Package for the one-shot timer bank: sizes, command codes and constants.
package ostb_pkg;

	localparam int NUM_TIMERS = 8;
	localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int MASK_W = 8;
	localparam int CMD_W = 2;
	localparam int INDEX_W = 3;
	localparam int TMO_W = 32;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_START = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [TMO_W-1:0] CLEARED_TIMEOUT = 32'hFFFF_FFF0;

	typedef logic [TMO_W-1:0] tmr_word_t;

endpackage

// ===== rtl/one_shot_soft_timer_bank_top.sv =====
// One-shot timer bank: start, clear and tick commands over a stream, one status word each.
// Start, clear and the unused code pass from acceptance to the done state, which loads the
// status word; a tick first walks all timers in the walk state, since one shared compare and
// increment unit walks the timers one per cycle. No new command is taken until the word is in
// the output register, and the done state holds while a shown word waits on m_tready.
// Reset stops every timer, clears all alarms and drops the output valid.
module one_shot_soft_timer_bank_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// timer_index [2:0], timeout_ticks [34:3], zero fill [39:35]
	input  logic [ostb_pkg::IN_DATA_W-1:0]  s_tdata,
	// command [1:0]
	input  logic [ostb_pkg::CMD_W-1:0]      s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// alarm_mask [7:0], running_mask [15:8]
	output logic [ostb_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ostb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]            state_q;
	logic [TIDX_W-1:0]     walk_q;
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] alarm_q;
	tmr_word_t             count_q [NUM_TIMERS];
	tmr_word_t             limit_q [NUM_TIMERS];
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic                  accept;
	logic [INDEX_W-1:0]    in_index;
	tmr_word_t             in_timeout;
	logic                  index_ok;
	logic [TIDX_W-1:0]     in_addr;
	tmr_word_t             cur_count;
	tmr_word_t             cur_limit;
	logic                  below;
	logic                  walk_last;
	logic                  out_free;
	logic [MASK_W-1:0]     alarm_mask;
	logic [MASK_W-1:0]     running_mask;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign in_index   = s_tdata[INDEX_W-1:0];
	assign in_timeout = s_tdata[INDEX_W +: TMO_W];
	assign index_ok   = (32'(in_index) < NUM_TIMERS);
	assign in_addr    = TIDX_W'(32'(in_index));

	// shared unit: compare and increment of the timer under the walk pointer
	assign cur_count = count_q[walk_q];
	assign cur_limit = limit_q[walk_q];
	assign below     = (cur_count < cur_limit);
	assign walk_last = (walk_q == TIDX_W'(NUM_TIMERS - 1));
	assign out_free  = !m_tvalid_q || m_tready;

	genvar gi;
	generate
		for (gi = 0; gi < MASK_W; gi++) begin : g_mask
			if (gi < NUM_TIMERS) begin : g_on
				assign alarm_mask[gi]   = alarm_q[gi];
				assign running_mask[gi] = running_q[gi];
			end else begin : g_off
				assign alarm_mask[gi]   = 1'b0;
				assign running_mask[gi] = 1'b0;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			walk_q     <= '0;
			running_q  <= '0;
			alarm_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_TICK) begin
							walk_q  <= '0;
							state_q <= ST_WALK;
						end else begin
							if (index_ok && s_tuser == CMD_START) begin
								alarm_q[in_addr]   <= 1'b0;
								running_q[in_addr] <= 1'b1;
							end else if (index_ok && s_tuser == CMD_CLEAR) begin
								alarm_q[in_addr]   <= 1'b0;
								running_q[in_addr] <= 1'b0;
							end
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					if (running_q[walk_q]) begin
						if (below) begin
							alarm_q[walk_q] <= 1'b0;
						end else begin
							running_q[walk_q] <= 1'b0;
							alarm_q[walk_q]   <= 1'b1;
						end
					end
					if (walk_last) begin
						state_q <= ST_DONE;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && index_ok && s_tuser == CMD_START) begin
			count_q[in_addr] <= '0;
			limit_q[in_addr] <= in_timeout;
		end else if (accept && index_ok && s_tuser == CMD_CLEAR) begin
			count_q[in_addr] <= '0;
			limit_q[in_addr] <= CLEARED_TIMEOUT;
		end else if (state_q == ST_WALK && running_q[walk_q] && below) begin
			count_q[walk_q] <= cur_count + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= {running_mask, alarm_mask};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
